// ===== rtl/spk_pkg.sv =====
`default_nettype none

package spk_pkg;

   // cipher geometry
   localparam int ROUNDS  = 27;
   localparam int WORD_W  = 32;
   localparam int BLOCK_W = 2 * WORD_W;
   localparam int KEY_W   = 2 * BLOCK_W;
   localparam int CNT_W   = (ROUNDS > 1) ? $clog2(ROUNDS) : 1;
   localparam int ROT_X   = 8;
   localparam int ROT_Y   = 3;

   // opcode values
   localparam logic OP_ENCRYPT = 1'b0;
   localparam logic OP_DECRYPT = 1'b1;

   typedef logic [WORD_W-1:0]  spk_word_type;
   typedef logic [BLOCK_W-1:0] spk_block_type;
   typedef logic [CNT_W-1:0]   spk_idx_type;

   localparam spk_idx_type LAST_IDX = CNT_W'(ROUNDS - 1);

   // command bundle from the controller to the datapath
   typedef struct packed {
      logic        load;
      logic        expand;
      logic        round;
      logic        emit;
      spk_idx_type idx;
   } spk_cmd_type;

   function automatic spk_word_type rotl(input spk_word_type v, input int s);
      return (v << s) | (v >> (WORD_W - s));
   endfunction

   function automatic spk_word_type rotr(input spk_word_type v, input int s);
      return (v >> s) | (v << (WORD_W - s));
   endfunction

   // one forward round, returns {x, y}
   function automatic spk_block_type round_fwd(input spk_word_type x,
                                               input spk_word_type y,
                                               input spk_word_type k);
      spk_word_type xn;
      xn = (rotr(x, ROT_X) + y) ^ k;
      return {xn, rotl(y, ROT_Y) ^ xn};
   endfunction

   // one inverse round, returns {x, y}
   function automatic spk_block_type round_inv(input spk_word_type x,
                                               input spk_word_type y,
                                               input spk_word_type k);
      spk_word_type yn;
      spk_word_type xn;
      yn = rotr(y ^ x, ROT_Y);
      xn = rotl((x ^ k) - yn, ROT_X);
      return {xn, yn};
   endfunction

endpackage

`default_nettype wire

// ===== rtl/speck64_128_cipher_core.sv =====
// Speck64/128 block cipher core, 27 rounds, one item at a time.
// Request channel (req_valid / req_stall): opcode (0 encrypt, 1 decrypt),
// the 128-bit key as key_low / key_high and the 64-bit block. A transfer
// takes place on a rising edge with valid high and stall low.
// Response channel (rsp_valid / rsp_stall): the 64-bit result, one per
// request, in request order.
// Each request first runs the key schedule, one round key per cycle, then
// 27 cipher rounds in forward or reverse key order, then loads the output
// register once it can take the result. req_stall stays high from the
// request transfer until the result is loaded, so the core takes no new
// request before it is through with the last one.
// The output register lets the next request start while a result still
// waits; if the receiver keeps rsp_stall high, the next result holds in
// the core and req_stall stays high until the output register frees up.
// Synchronous reset empties the core: no request in flight, rsp_valid low.
`default_nettype none

module speck64_128_cipher_core
   import spk_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic        req_opcode,
   input  wire logic [63:0] req_key_low,
   input  wire logic [63:0] req_key_high,
   input  wire logic [63:0] req_block,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [63:0]      rsp_result
);

   spk_cmd_type cmd;

   spk_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd)
   );

   spk_datapath u_datapath (
      .clock        (clock),
      .cmd          (cmd),
      .req_opcode   (req_opcode),
      .req_key_low  (req_key_low),
      .req_key_high (req_key_high),
      .req_block    (req_block),
      .rsp_result   (rsp_result)
   );

endmodule

`default_nettype wire

// ===== rtl/spk_datapath.sv =====
`default_nettype none

module spk_datapath
   import spk_pkg::*;
(
   input  wire logic          clock,
   input  wire spk_cmd_type   cmd,
   input  wire logic          req_opcode,
   input  wire logic [63:0]   req_key_low,
   input  wire logic [63:0]   req_key_high,
   input  wire logic [63:0]   req_block,
   output logic [63:0]        rsp_result
);

   spk_word_type  rk_ff [ROUNDS];
   spk_word_type  a_ff, a_in;
   spk_word_type  q0_ff, q0_in;
   spk_word_type  q1_ff, q1_in;
   spk_word_type  q2_ff, q2_in;
   spk_word_type  x_ff, x_in;
   spk_word_type  y_ff, y_in;
   logic          dec_ff, dec_in;
   spk_block_type result_ff, result_in;

   spk_block_type exp_step;
   spk_block_type fwd_step;
   spk_block_type inv_step;
   spk_idx_type   key_idx;
   spk_word_type  round_key;

   // key schedule step: the current key word and a, round index as key
   assign exp_step = round_fwd(q0_ff, a_ff, {{(WORD_W - CNT_W){1'b0}}, cmd.idx});

   // pick the round key: forward order to encrypt, reverse to decrypt
   assign key_idx   = (dec_ff == OP_DECRYPT) ? (LAST_IDX - cmd.idx) : cmd.idx;
   assign round_key = rk_ff[key_idx];
   assign fwd_step  = round_fwd(x_ff, y_ff, round_key);
   assign inv_step  = round_inv(x_ff, y_ff, round_key);

   always_comb begin
      a_in      = a_ff;
      q0_in     = q0_ff;
      q1_in     = q1_ff;
      q2_in     = q2_ff;
      x_in      = x_ff;
      y_in      = y_ff;
      dec_in    = dec_ff;
      result_in = result_ff;
      if (cmd.load) begin
         // capture the item
         dec_in = req_opcode;
         a_in   = req_key_low[WORD_W-1:0];
         q0_in  = req_key_low[BLOCK_W-1:WORD_W];
         q1_in  = req_key_high[WORD_W-1:0];
         q2_in  = req_key_high[BLOCK_W-1:WORD_W];
         x_in   = req_block[BLOCK_W-1:WORD_W];
         y_in   = req_block[WORD_W-1:0];
      end else if (cmd.expand) begin
         // rotate the key words, updated word goes to the back
         a_in  = exp_step[WORD_W-1:0];
         q0_in = q1_ff;
         q1_in = q2_ff;
         q2_in = exp_step[BLOCK_W-1:WORD_W];
      end else if (cmd.round) begin
         if (dec_ff == OP_DECRYPT) begin
            x_in = inv_step[BLOCK_W-1:WORD_W];
            y_in = inv_step[WORD_W-1:0];
         end else begin
            x_in = fwd_step[BLOCK_W-1:WORD_W];
            y_in = fwd_step[WORD_W-1:0];
         end
      end
      if (cmd.emit) begin
         result_in = {x_ff, y_ff};
      end
   end

   always_ff @(posedge clock) begin
      a_ff      <= a_in;
      q0_ff     <= q0_in;
      q1_ff     <= q1_in;
      q2_ff     <= q2_in;
      x_ff      <= x_in;
      y_ff      <= y_in;
      dec_ff    <= dec_in;
      result_ff <= result_in;
      // store the round key of this schedule step
      if (cmd.expand) begin
         rk_ff[cmd.idx] <= a_ff;
      end
   end

   assign rsp_result = result_ff;

endmodule

`default_nettype wire

// ===== rtl/spk_ctrl.sv =====
`default_nettype none

module spk_ctrl
   import spk_pkg::*;
(
   input  wire logic   clock,
   input  wire logic   reset,
   input  wire logic   req_valid,
   output logic        req_stall,
   output logic        rsp_valid,
   input  wire logic   rsp_stall,
   output spk_cmd_type cmd
);

   typedef enum logic [1:0] {
      IDLE_ST,
      EXPAND_ST,
      ROUND_ST,
      EMIT_ST
   } state_type;

   state_type   state_ff, state_in;
   spk_idx_type cnt_ff, cnt_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic        out_free;

   // output register is free, or its transfer completes this cycle
   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      rsp_valid_in = rsp_valid_ff;
      cmd          = '0;
      cmd.idx      = cnt_ff;
      // drop valid once the result transfer completes
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      case (state_ff)
         IDLE_ST: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               cnt_in   = '0;
               state_in = EXPAND_ST;
            end
         end
         EXPAND_ST: begin
            cmd.expand = 1'b1;
            if (cnt_ff == LAST_IDX) begin
               cnt_in   = '0;
               state_in = ROUND_ST;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         ROUND_ST: begin
            cmd.round = 1'b1;
            if (cnt_ff == LAST_IDX) begin
               cnt_in   = '0;
               state_in = EMIT_ST;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         EMIT_ST: begin
            // hold until the output register can take the result
            if (out_free) begin
               cmd.emit     = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = IDLE_ST;
            end
         end
         default: begin
            state_in = IDLE_ST;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= IDLE_ST;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_stall = (state_ff != IDLE_ST);
   assign rsp_valid = rsp_valid_ff;

   // a result is never written over one that is still waiting
   assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> out_free)
      else $error("result register overwritten while stalled");

   // an accepted item starts the key schedule
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> (state_ff == EXPAND_ST && cnt_ff == '0))
      else $error("accepted item did not start key expansion");

   // the last round leads straight to the emit step
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ROUND_ST && cnt_ff == LAST_IDX) |=> (state_ff == EMIT_ST))
      else $error("round sequence did not end in emit");

   // the step counter stays within the round count
   assert property (@(posedge clock) disable iff (reset)
      (cnt_ff <= LAST_IDX))
      else $error("step counter out of range");

endmodule

`default_nettype wire

// ===== dv/speck64_128_cipher_check.sv =====
`timescale 1ns / 1ps

module speck64_128_cipher_check
   import spk_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   input  wire logic        req_stall,
   input  wire logic        req_opcode,
   input  wire logic [63:0] req_key_low,
   input  wire logic [63:0] req_key_high,
   input  wire logic [63:0] req_block,
   input  wire logic        rsp_valid,
   input  wire logic        rsp_stall,
   input  wire logic [63:0] rsp_result,
   output int               mismatches,
   output int               pending
);

   // results predicted for accepted requests, oldest first
   spk_block_type predicted_blocks[$];
   int            fail_cnt = 0;

   assign mismatches = fail_cnt;

   function automatic spk_word_type ror32(input spk_word_type v, input int unsigned s);
      logic [63:0] twice;
      twice = {v, v} >> s;
      return twice[31:0];
   endfunction

   function automatic spk_word_type rol32(input spk_word_type v, input int unsigned s);
      logic [63:0] twice;
      twice = {v, v} << s;
      return twice[63:32];
   endfunction

   // expand the key, then run all rounds forward or in reverse key order
   function automatic spk_block_type speck_transform(input logic          op,
                                                     input logic [63:0]   key_lo,
                                                     input logic [63:0]   key_hi,
                                                     input spk_block_type blk);
      spk_word_type sched [ROUNDS];
      spk_word_type lw [3];
      spk_word_type a;
      spk_word_type x;
      spk_word_type y;
      int           i;
      a     = key_lo[31:0];
      lw[0] = key_lo[63:32];
      lw[1] = key_hi[31:0];
      lw[2] = key_hi[63:32];
      for (i = 0; i < ROUNDS; i++) begin
         sched[i] = a;
         if (i < ROUNDS - 1) begin
            lw[i % 3] = (ror32(lw[i % 3], ROT_X) + a) ^ spk_word_type'(i);
            a = rol32(a, ROT_Y) ^ lw[i % 3];
         end
      end
      x = blk[63:32];
      y = blk[31:0];
      if (op == OP_DECRYPT) begin
         for (i = ROUNDS - 1; i >= 0; i--) begin
            y = ror32(y ^ x, ROT_Y);
            x = rol32((x ^ sched[i]) - y, ROT_X);
         end
      end else begin
         for (i = 0; i < ROUNDS; i++) begin
            x = (ror32(x, ROT_X) + y) ^ sched[i];
            y = rol32(y, ROT_Y) ^ x;
         end
      end
      return {x, y};
   endfunction

   // sanity-check the predictor against the published Speck64/128 vector
   initial begin
      if (speck_transform(OP_ENCRYPT, 64'h0b0a0908_03020100, 64'h1b1a1918_13121110,
                          64'h3b726574_7475432d) !== 64'h8c6fa548_454e028b) begin
         $display("%0t: predictor disagrees with the published test vector", $time);
         fail_cnt++;
      end
   end

   // compare each result transfer, then queue the prediction for a new request
   always @(posedge clock) begin
      spk_block_type want;
      if (reset) begin
         predicted_blocks.delete();
         pending <= 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (predicted_blocks.size() == 0) begin
               $display("%0t: unexpected result: expected none, actual %h",
                        $time, rsp_result);
               fail_cnt++;
            end else begin
               want = predicted_blocks.pop_front();
               if (rsp_result !== want) begin
                  $display("%0t: result mismatch: expected %h, actual %h",
                           $time, want, rsp_result);
                  fail_cnt++;
               end
            end
         end
         if (req_valid && !req_stall)
            predicted_blocks.push_back(speck_transform(req_opcode, req_key_low,
                                                       req_key_high, req_block));
         pending <= predicted_blocks.size();
      end
   end

endmodule

// ===== dv/speck64_128_cipher_core_test.sv =====
`timescale 1ns / 1ps

module speck64_128_cipher_core_test
   import spk_pkg::*;
();

   localparam int IDLE_LIMIT   = 4000;
   localparam int RANDOM_ITEMS = 600;
   localparam int DRAIN_CYCLES = 64;

   logic        clock        = 1'b0;
   logic        reset        = 1'b1;
   logic        req_valid    = 1'b0;
   logic        req_stall;
   logic        req_opcode   = OP_ENCRYPT;
   logic [63:0] req_key_low  = '0;
   logic [63:0] req_key_high = '0;
   logic [63:0] req_block    = '0;
   logic        rsp_valid;
   logic        rsp_stall    = 1'b0;
   logic [63:0] rsp_result;

   logic        quiet        = 1'b0;
   int          stall_left   = 0;
   int          idle_cycles  = 0;
   int          mismatches;
   int          pending;

   always #10 clock = ~clock;

   speck64_128_cipher_core i_dut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_opcode   (req_opcode),
      .req_key_low  (req_key_low),
      .req_key_high (req_key_high),
      .req_block    (req_block),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_result   (rsp_result)
   );

   speck64_128_cipher_check i_check (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_opcode   (req_opcode),
      .req_key_low  (req_key_low),
      .req_key_high (req_key_high),
      .req_block    (req_block),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_result   (rsp_result),
      .mismatches   (mismatches),
      .pending      (pending)
   );

   // mostly short gaps, now and then a long one
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 50) return 0;
      if (r < 85) return $urandom_range(1, 8);
      if (r < 97) return $urandom_range(9, 80);
      return $urandom_range(81, 250);
   endfunction

   // random word biased toward all-zero, all-one and one-hot values
   function automatic spk_word_type rand_word();
      case ($urandom_range(0, 15))
         0: return '0;
         1: return '1;
         2: return spk_word_type'(1) << $urandom_range(0, 31);
         default: return $urandom();
      endcase
   endfunction

   // offer one request, hold it until the transfer, then idle for a random, possibly empty, gap
   task automatic send_item(input logic op, input logic [63:0] kl, input logic [63:0] kh,
                            input logic [63:0] blk);
      int gap;
      req_valid    <= 1'b1;
      req_opcode   <= op;
      req_key_low  <= kl;
      req_key_high <= kh;
      req_block    <= blk;
      do @(posedge clock); while (req_stall);
      gap = quiet ? 0 : pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // hold off new requests until every predicted result has come back
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
   endtask

   // receiver: random stall runs, none while quiet
   always @(posedge clock) begin
      if (quiet) begin
         rsp_stall  <= 1'b0;
         stall_left <= 0;
      end else if (stall_left == 0) begin
         rsp_stall  <= ($urandom_range(0, 2) == 0);
         stall_left <= pick_gap();
      end else begin
         stall_left <= stall_left - 1;
      end
   end

   // watchdog: end the run after too long without any transfer
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      logic [63:0] kl;
      logic [63:0] kh;
      int          n;

      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: extremes, both operations, published vector both ways
      send_item(OP_ENCRYPT, '0, '0, '0);
      send_item(OP_DECRYPT, '0, '0, '0);
      send_item(OP_ENCRYPT, '1, '1, '1);
      send_item(OP_DECRYPT, '1, '1, '1);
      send_item(OP_ENCRYPT, 64'h0b0a0908_03020100, 64'h1b1a1918_13121110,
                64'h3b726574_7475432d);
      send_item(OP_DECRYPT, 64'h0b0a0908_03020100, 64'h1b1a1918_13121110,
                64'h8c6fa548_454e028b);
      send_item(OP_ENCRYPT, {16{4'h5}}, {16{4'ha}}, {16{4'h5}});
      send_item(OP_DECRYPT, {16{4'ha}}, {16{4'h5}}, {16{4'ha}});
      send_item(OP_ENCRYPT, '1, '0, '0);
      send_item(OP_DECRYPT, '0, '1, '1);
      send_item(OP_ENCRYPT, 64'h1, 64'h8000_0000_0000_0000, 64'h8000_0000_0000_0001);
      send_item(OP_DECRYPT, 64'h8000_0000_0000_0000, 64'h1, 64'h0000_0001_8000_0000);
      send_item(OP_ENCRYPT, '0, '0, '1);
      send_item(OP_DECRYPT, '1, '1, '0);
      drain();

      // random: reused keys now and then, quiet stretches with no idling
      kl = '0;
      kh = '0;
      for (n = 0; n < RANDOM_ITEMS; n++) begin
         quiet <= ((n / 100) % 3 == 1);
         if (n == RANDOM_ITEMS / 2)
            drain();
         if (n == 0 || $urandom_range(0, 3) != 0) begin
            kl = {rand_word(), rand_word()};
            kh = {rand_word(), rand_word()};
         end
         send_item(logic'($urandom_range(0, 1)), kl, kh, {rand_word(), rand_word()});
      end

      // let the last results out, then give the verdict
      quiet <= 1'b0;
      drain();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0 && pending == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
